/* hdl/tcf_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the tilt filter.
// Used by tcf_cordic, tilt_complementary_filter and its testbench; depends on nothing.
package tcf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_DEF   = 8;
  localparam int ZW               = 27;  // CORDIC angle, degrees Q16 incl. +-180 offset
  localparam int XW               = 28;  // CORDIC vector components
  localparam int BLEND_W          = 17;
  localparam int GAIN_W           = 18;
  localparam int PERIOD_W         = 25;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_PRED,
    ST_LMIX,
    ST_MIX,
    ST_WB
  } state_t;

  typedef enum logic [1:0] {
    REG_BLEND  = 2'd0,
    REG_GAIN   = 2'd1,
    REG_PERIOD = 2'd2
  } reg_idx_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/tcf_cordic.sv */
// Iterative vectoring CORDIC: atan2(ax, az) in degrees Q16, one rotation per cycle.
// Depends on tcf_pkg.
module tcf_cordic #(
  parameter int STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [15:0]            ax,
  input  logic signed [15:0]            az,
  output logic                          done,
  output logic signed [tcf_pkg::ZW-1:0] z_out
);
  import tcf_pkg::*;

  localparam int IW = $clog2(STEPS);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);

  logic signed [XW-1:0] x, y, xs, ys, xe, ye;
  logic signed [ZW-1:0] z, at;
  logic [IW-1:0]        i;
  logic                 busy, zero;

  assign xs = x >>> i;
  assign ys = y >>> i;
  assign at = ZW'(atan_q16(5'(i)));
  assign xe = XW'(az);
  assign ye = XW'(ax);
  assign z_out = zero ? '0 : z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      zero <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
        zero <= (ax == 16'sd0) && (az == 16'sd0);
        // left half plane: mirror the vector, fold +-180 into z
        if (az < 0) begin
          x <= (-xe) <<< 8;
          y <= (-ye) <<< 8;
          z <= (ax >= 0) ? DEG180 : -DEG180;
        end else begin
          x <= xe <<< 8;
          y <= ye <<< 8;
          z <= '0;
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end
        i <= i + 1'b1;
        if (i == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/tilt_complementary_filter.sv */
// Top level of the tilt complementary filter.
// Depends on tcf_pkg and tcf_cordic.
//
// Pitch estimator for one accelerometer/gyro sample per input transfer. The gyro
// count is scaled by rate_gain into deg/s Q.8, the accelerometer pitch
// atan2(accel_x, accel_z) comes from an iterative CORDIC, and the two are blended
// as angle = alpha*(angle + rate*period) + (1-alpha)*accel_pitch, all rounding
// half up, angle saturated to +-180 degrees. A sample with read_ok low holds the
// angle and reports zero rate and accel angle. All products go through one
// bit-serial shift-add multiplier that retires one multiplier bit per cycle, in
// order: the gyro scale (run alongside the CORDIC), rate*period, a step that
// loads the blend operands, the blend, then write-back. The next sample is
// accepted once the state machine is back in idle after write-back. A failed
// read skips the multiplier and CORDIC and goes straight to write-back. One
// sample is in flight at a time; the result sits in an output register until
// taken, and write-back waits while that register is full.
module tilt_complementary_filter #(
  parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [24:0] cfg_data,
  // sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // accel_x[15:0], accel_z[31:16], gyro_y[47:32]
  input  logic        s_tuser,   // read_ok
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // tilt_angle[16:0], accel_tilt[33:17], turn_rate[51:34]
  output logic        m_tuser    // updated
);
  import tcf_pkg::*;

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int AW = F + 10;   // internal angle width
  localparam int PW = 44;       // multiplicand
  localparam int MW = 62;       // accumulator
  localparam logic signed [AW-1:0] LIM      = AW'(180 << F);
  localparam logic signed [MW-1:0] LIM_W    = MW'(LIM);
  localparam logic signed [ZW-1:0] LIM_Z    = ZW'(LIM);
  localparam logic signed [MW-1:0] RATE_MAX = MW'(131071);
  localparam logic signed [MW-1:0] RATE_MIN = -MW'(131072);

  // config registers
  logic [BLEND_W-1:0]  blend_weight;
  logic [GAIN_W-1:0]   rate_gain;
  logic [PERIOD_W-1:0] sample_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight  <= BLEND_W'(64225);
      rate_gain     <= GAIN_W'(128072);
      sample_period <= PERIOD_W'(16777);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BLEND:  blend_weight  <= cfg_data[BLEND_W-1:0];
        REG_GAIN:   rate_gain     <= cfg_data[GAIN_W-1:0];
        REG_PERIOD: sample_period <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  logic signed [MW-1:0] acc, acc_next, base, pterm, aterm, addend;
  logic signed [PW-1:0] mcand;
  logic [24:0]          mplier;
  logic [4:0]           cnt;
  logic                 first, mbusy, cdone, ok;
  logic signed [AW-1:0] fa, accang, fa_new, accang_v;
  logic signed [17:0]   rate, rate_v;
  logic signed [MW-1:0] rate_sh, ang_sh, faup, accup;
  logic signed [ZW-1:0] cz, zr;
  logic                 cstart, cfin, step, in_xfer, out_free;
  logic [BLEND_W-1:0]   alpha;

  tcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cstart),
    .ax    (s_tdata[15:0]),
    .az    (s_tdata[31:16]),
    .done  (cfin),
    .z_out (cz)
  );

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign cstart   = in_xfer && s_tuser;
  assign out_free = !m_tvalid || m_tready;
  assign alpha    = blend_weight[BLEND_W-1] ? BLEND_W'(65536) : blend_weight;

  // shared shift-add multiplier, MSB of mplier first; addend folded in on the last bit
  assign step  = (state == ST_CALC && mbusy) || state == ST_PRED || state == ST_MIX;
  assign faup  = MW'(fa) <<< (32 - F);
  assign accup = MW'(accang) <<< (32 - F);

  always_comb begin
    case (state)
      ST_CALC: addend = MW'(1) <<< 15;
      ST_PRED: addend = faup;
      default: addend = (accup <<< 16) + (MW'(1) <<< (47 - F));
    endcase
    base     = first ? '0 : (acc <<< 1);
    pterm    = mplier[24] ? MW'(mcand) : '0;
    aterm    = (cnt == 5'd0) ? addend : '0;
    acc_next = base + pterm + aterm;
  end

  // rounding and saturation of finished products
  always_comb begin
    rate_sh = acc >>> 16;
    if (rate_sh > RATE_MAX)      rate_v = 18'sd131071;
    else if (rate_sh < RATE_MIN) rate_v = -18'sd131072;
    else                         rate_v = 18'(rate_sh);

    ang_sh = acc >>> (48 - F);
    if (ang_sh > LIM_W)       fa_new = LIM;
    else if (ang_sh < -LIM_W) fa_new = -LIM;
    else                      fa_new = AW'(ang_sh);

    zr = (cz + (ZW'(1) <<< (15 - F))) >>> (16 - F);
    if (zr > LIM_Z)       accang_v = LIM;
    else if (zr < -LIM_Z) accang_v = -LIM;
    else                  accang_v = AW'(zr);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = s_tuser ? ST_CALC : ST_WB;
      ST_CALC: if (!mbusy && cdone) state_next = ST_PRED;
      ST_PRED: if (cnt == 5'd0) state_next = ST_LMIX;
      ST_LMIX: state_next = ST_MIX;
      ST_MIX:  if (cnt == 5'd0) state_next = ST_WB;
      ST_WB:   if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy    <= 1'b0;
      cdone    <= 1'b0;
      fa       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // write-back reloads the output register itself
      if (m_tvalid && m_tready && state != ST_WB) m_tvalid <= 1'b0;
      if (cfin) begin
        cdone  <= 1'b1;
        accang <= accang_v;
      end
      if (step) begin
        acc    <= acc_next;
        mplier <= mplier << 1;
        cnt    <= cnt - 1'b1;
        first  <= 1'b0;
        if (state == ST_CALC && cnt == 5'd0) mbusy <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (in_xfer) begin
          ok    <= s_tuser;
          cdone <= 1'b0;
          if (s_tuser) begin
            mbusy  <= 1'b1;
            mcand  <= PW'($signed(s_tdata[47:32]));
            mplier <= {rate_gain, 7'b0};
            cnt    <= 5'd17;
            first  <= 1'b1;
          end else begin
            rate   <= '0;
            accang <= '0;
          end
        end
        ST_CALC: if (!mbusy && cdone) begin
          rate   <= rate_v;
          mcand  <= PW'(rate_v);
          mplier <= sample_period;
          cnt    <= 5'd24;
          first  <= 1'b1;
        end
        ST_LMIX: begin
          mcand  <= PW'(acc) - PW'(accup);
          mplier <= {alpha, 8'b0};
          cnt    <= 5'd16;
          first  <= 1'b1;
        end
        ST_WB: if (out_free) begin
          m_tvalid <= 1'b1;
          m_tuser  <= ok;
          if (ok) fa <= fa_new;
          m_tdata  <= {4'b0, rate, 17'(accang), 17'(ok ? fa_new : fa)};
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_held_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[51:17] == '0)
    else $error("held sample carries nonzero rate or accel angle");
  a_fail_fast: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !s_tuser |=> state == ST_WB)
    else $error("failed read did not go straight to write-back");
  a_angle_lim: assert property (@(posedge clk) disable iff (rst)
    fa <= LIM && fa >= -LIM)
    else $error("kept angle outside +-180 degrees");
`endif

endmodule

/* verif/tilt_complementary_filter_test.sv */
// Testbench for tilt_complementary_filter: drives IMU samples over the input stream,
// predicts tilt, accel angle and rate in a local model, and checks every result.
// Depends on tcf_pkg and the RTL of the filter.
`timescale 1ns / 1ps

module tilt_complementary_filter_test;
  import tcf_pkg::*;

  localparam int FRAC = 8;
  localparam longint LIM = longint'(180) << FRAC;

  typedef struct packed {
    logic signed [17:0] rate;
    logic signed [16:0] acc;
    logic signed [16:0] tilt;
  } tilt_out_t;

  typedef struct {
    tilt_out_t data;
    logic      upd;
  } tilt_expect_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [24:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tuser;

  // local copy of the filter state and registers
  longint alpha_q16, gain_q16, period_q24, angle_q8;

  tilt_expect_t pending_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  tilt_complementary_filter dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;  // arithmetic shift is floor division
  endfunction

  function automatic longint round_shift(longint v, int s);
    return floor_shift(v + (longint'(1) << (s - 1)), s);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // vectoring CORDIC, degrees Q16
  function automatic longint pitch_q16(longint y, longint x);
    longint ofs, z, dx, dy;
    ofs = 0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ofs = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_q16(i[4:0]));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_q16(i[4:0]));
      end
    end
    return z + ofs;
  endfunction

  // advance the local filter by one sample and return what the block should give
  function automatic tilt_expect_t filter_sample(logic [15:0] ax, logic [15:0] az,
                                                 logic [15:0] gy, logic ok);
    tilt_expect_t e;
    longint a, rate, acc, pred, mix, up;
    rate = 0;
    acc = 0;
    if (ok) begin
      a = alpha_q16 > 65536 ? 65536 : alpha_q16;
      up = longint'(1) << (32 - FRAC);
      rate = clip(round_shift(longint'($signed(gy)) * gain_q16, 16), -131072, 131071);
      acc = clip(round_shift(pitch_q16(longint'($signed(ax)), longint'($signed(az))),
                             16 - FRAC), -LIM, LIM);
      pred = angle_q8 * up + rate * period_q24;
      mix = a * pred + (65536 - a) * (acc * up);
      angle_q8 = clip(round_shift(mix, 48 - FRAC), -LIM, LIM);
    end
    e.data.tilt = angle_q8[16:0];
    e.data.acc = acc[16:0];
    e.data.rate = rate[17:0];
    e.upd = ok;
    return e;
  endfunction

  task automatic cfg_write(reg_idx_t idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val[24:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BLEND:  alpha_q16 = val & 64'h1FFFF;
      REG_GAIN:   gain_q16 = val & 64'h3FFFF;
      default:    period_q24 = val & 64'h1FFFFFF;
    endcase
  endtask

  // one sample transfer; expectation queued at acceptance, valid left high
  // so the next sample can follow at once
  task automatic send_sample(logic [15:0] ax, logic [15:0] az, logic [15:0] gy, logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {gy, az, ax};
    s_tuser <= ok;
    do @(posedge clk); while (!s_tready);
    pending_q.push_back(filter_sample(ax, az, gy, ok));
    samples_sent++;
  endtask

  // drop valid, wait until every expected result has arrived, then a settling margin
  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  // receiver: random stalls, checks each transfer against the oldest prediction
  always @(posedge clk) begin
    tilt_expect_t e;
    tilt_out_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[51:0];
        results_seen++;
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          e = pending_q.pop_front();
          if (got.tilt !== e.data.tilt || got.acc !== e.data.acc ||
              got.rate !== e.data.rate || m_tuser !== e.upd) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: tilt %0d/%0d acc %0d/%0d rate %0d/%0d upd %b/%b (exp/got)",
                       e.data.tilt, got.tilt, e.data.acc, got.acc,
                       e.data.rate, got.rate, e.upd, m_tuser);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic rand_sample();
    logic [15:0] ax, az, gy;
    ax = 16'($urandom);
    az = 16'($urandom);
    gy = 16'($urandom);
    case ($urandom_range(3))
      0: begin
        ax = 16'($urandom_range(200) - 100);
        az = 16'($urandom_range(200) - 100);
      end
      1: gy = 16'($urandom_range(2000) - 1000);
      default: ;
    endcase
    send_sample(ax, az, gy, $urandom_range(9) != 0);
  endtask

  task automatic test_directed();
    send_sample(16'h0000, 16'h0000, 16'h0000, 1'b1);       // zero vector
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send_sample(16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_sample(16'h7FFF, 16'h8000, 16'h0001, 1'b1);       // negative z, x >= 0
    send_sample(16'h8000, 16'h7FFF, 16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 16'h8000, 16'h1234, 1'b1);       // negative z, x < 0
    send_sample(16'h0000, 16'hFFFF, 16'h0000, 1'b1);       // straight down
    send_sample(16'h0000, 16'h0001, 16'h0000, 1'b1);
    send_sample(16'h0001, 16'h0000, 16'h0000, 1'b1);
    send_sample(16'hFFFF, 16'h0000, 16'h0000, 1'b1);
    send_sample(16'h5555, 16'hAAAA, 16'h5555, 1'b0);       // failed read holds
    send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
    send_sample(16'h1000, 16'h1000, 16'h7FFF, 1'b1);
    drain();
  endtask

  task automatic test_extreme_regs();
    cfg_write(REG_BLEND, 65536 + 30000);  // above one acts as one
    cfg_write(REG_GAIN, 262143);
    cfg_write(REG_PERIOD, 16777216);
    for (int i = 0; i < 12; i++) send_sample(16'h0100, 16'h0100, 16'h7FFF, 1'b1);
    for (int i = 0; i < 4; i++) send_sample(16'h0100, 16'h0100, 16'h8000, 1'b1);
    drain();
    cfg_write(REG_BLEND, 0);
    cfg_write(REG_GAIN, 0);
    cfg_write(REG_PERIOD, 0);
    for (int i = 0; i < 8; i++) rand_sample();
    drain();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    cfg_write(REG_BLEND, longint'($urandom_range(65536 + 200)));
    cfg_write(REG_GAIN, longint'($urandom_range(262143)));
    cfg_write(REG_PERIOD, longint'($urandom_range(16777216)));
    for (int i = 0; i < count; i++) rand_sample();
    drain();
  endtask

  task automatic test_defaults(int count);
    cfg_write(REG_BLEND, 64225);
    cfg_write(REG_GAIN, 128072);
    cfg_write(REG_PERIOD, 16777);
    for (int i = 0; i < count; i++) rand_sample();
    drain();
  endtask

  initial begin
    alpha_q16 = 64225;
    gain_q16 = 128072;
    period_q24 = 16777;
    angle_q8 = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extreme_regs();
    test_random_phase(0, 0, 220);
    test_random_phase(72, 0, 220);
    test_random_phase(0, 72, 220);
    test_random_phase(36, 36, 220);
    test_defaults(60);
    $display("covered %0d samples, %0d results checked, extreme and random register settings",
             samples_sent, results_seen);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("[tilt_complementary_filter] OK");
    else
      $display("[tilt_complementary_filter] ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("[tilt_complementary_filter] ERROR");
    $finish;
  end

endmodule

/* sim.f */
hdl/tcf_pkg.sv
hdl/tcf_cordic.sv
hdl/tilt_complementary_filter.sv
verif/tilt_complementary_filter_test.sv
